// ===== sv/rgse_pkg.sv =====
// shared types, constants and helpers for the rgb gray sobel edge block
package rgse_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ROW_LIMIT = 1024;
    localparam int PIX_W     = 8;
    localparam int SIZE_W    = 11;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(ROW_LIMIT);
    localparam int CFG_IDX_W = 1;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int LUMA_W   = 24;
    localparam logic [LUMA_W-1:0] LUMA_B = 24'd4732;
    localparam logic [LUMA_W-1:0] LUMA_G = 24'd46871;
    localparam logic [LUMA_W-1:0] LUMA_R = 24'd13933;

    localparam int GSUM_W = PIX_W + 3;
    localparam int GDIF_W = GSUM_W + 1;
    localparam int MAG_W  = GSUM_W + 1;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    localparam logic [SIZE_W-1:0] SIZE_MIN    = 11'd3;
    localparam logic [SIZE_W-1:0] WIDTH_RST   = 11'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST  = 11'd480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } size_cfg_t;

    // sobel neighborhood without the center, plus end markers
    typedef struct packed {
        pix_t t0;
        pix_t t1;
        pix_t t2;
        pix_t m0;
        pix_t m2;
        pix_t b0;
        pix_t b1;
        pix_t b2;
        logic row_end;
        logic frame_end;
    } win_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_MIN)
            r = SIZE_MIN;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== sv/rgse_ram.sv =====
// generic single write port ram with registered read
module rgse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/rgse_front.sv =====
// front end: pixel accept, raster counters, luma, line buffers and window
module rgse_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rgse_pkg::size_cfg_t        size_cfg,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [rgse_pkg::PIX_W-1:0] blue,
    input  logic [rgse_pkg::PIX_W-1:0] green,
    input  logic [rgse_pkg::PIX_W-1:0] red,
    input  logic [rgse_pkg::QCNT_W-1:0] q_count,
    output logic                       push,
    output rgse_pkg::win_t             push_win
);
    import rgse_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // second stage registers
    logic             b_valid_reg;
    logic             b_produce_reg;
    logic             b_last_col_reg;
    logic             b_last_row_reg;
    logic [COL_W-1:0] b_col_reg;
    pix_t             b_blue_reg, b_green_reg, b_red_reg;

    pix_t win_reg [3][3];

    logic              accept;
    logic              last_col, last_row, produce;
    logic [QCNT_W:0]   inflight;
    pix_t              top_rd, mid_rd, gray;
    logic [LUMA_W-1:0] luma_sum;

    // room in the queue counts the word still in the second stage
    assign inflight = {1'b0, q_count} + {{QCNT_W{1'b0}}, b_valid_reg};
    assign in_stall = (inflight >= (QCNT_W+1)'(QDEPTH));
    assign accept   = in_valid && !in_stall;

    assign last_col = (({1'b0, col_reg} + SIZE_W'(1)) >= size_cfg.width);
    assign last_row = (({1'b0, row_reg} + SIZE_W'(1)) >= size_cfg.height);
    assign produce  = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_produce_reg  <= produce;
            b_last_col_reg <= last_col;
            b_last_row_reg <= last_row;
            b_col_reg      <= col_reg;
            b_blue_reg     <= blue;
            b_green_reg    <= green;
            b_red_reg      <= red;
        end
    end

    // line buffers are read on accept, written back in the cycle after
    rgse_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_col_reg),
        .wdata (mid_rd),
        .raddr (col_reg),
        .rdata (top_rd)
    );

    rgse_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_above (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_col_reg),
        .wdata (gray),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    // q16 luma, truncated
    assign luma_sum = ({{(LUMA_W-PIX_W){1'b0}}, b_blue_reg}  * LUMA_B)
                    + ({{(LUMA_W-PIX_W){1'b0}}, b_green_reg} * LUMA_G)
                    + ({{(LUMA_W-PIX_W){1'b0}}, b_red_reg}   * LUMA_R);
    assign gray = luma_sum[LUMA_W-1 -: PIX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (b_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_rd;
            win_reg[1][2] <= mid_rd;
            win_reg[2][2] <= gray;
        end
    end

    assign push = b_valid_reg && b_produce_reg;

    always_comb
    begin
        push_win.t0        = win_reg[0][1];
        push_win.t1        = win_reg[0][2];
        push_win.t2        = top_rd;
        push_win.m0        = win_reg[1][1];
        push_win.m2        = mid_rd;
        push_win.b0        = win_reg[2][1];
        push_win.b1        = win_reg[2][2];
        push_win.b2        = gray;
        push_win.row_end   = b_last_col_reg;
        push_win.frame_end = b_last_col_reg && b_last_row_reg;
    end

    a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> $past(accept))
        else $error("second stage active without an accepted pixel");

endmodule

// ===== sv/rgse_queue.sv =====
// short fifo of sobel windows between front and back
module rgse_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  rgse_pkg::win_t              push_win,
    input  logic                        pop,
    output logic                        q_valid,
    output rgse_pkg::win_t              head,
    output logic [rgse_pkg::QCNT_W-1:0] count
);
    import rgse_pkg::*;

    win_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_win;
    end

    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign count   = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QCNT_W'(QDEPTH)))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from an empty queue");

endmodule

// ===== sv/rgse_back.sv =====
// back end: sobel gradients, magnitude and output register
module rgse_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  rgse_pkg::win_t             head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [rgse_pkg::PIX_W-1:0] edge_magnitude,
    output logic                       row_end,
    output logic                       frame_end
);
    import rgse_pkg::*;

    logic             out_valid_reg, out_valid_next;
    pix_t             mag_reg;
    logic             row_end_reg, frame_end_reg;

    logic [GSUM_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic [GDIF_W-1:0] gx, gy;
    logic [GSUM_W-1:0] gx_abs, gy_abs;
    logic [MAG_W-1:0]  mag_sum;
    pix_t              mag;

    assign gx_pos = GSUM_W'(head.t2) + {(GSUM_W-1)'(head.m2), 1'b0} + GSUM_W'(head.b2);
    assign gx_neg = GSUM_W'(head.t0) + {(GSUM_W-1)'(head.m0), 1'b0} + GSUM_W'(head.b0);
    assign gy_pos = GSUM_W'(head.b0) + {(GSUM_W-1)'(head.b1), 1'b0} + GSUM_W'(head.b2);
    assign gy_neg = GSUM_W'(head.t0) + {(GSUM_W-1)'(head.t1), 1'b0} + GSUM_W'(head.t2);

    assign gx = {1'b0, gx_pos} - {1'b0, gx_neg};
    assign gy = {1'b0, gy_pos} - {1'b0, gy_neg};

    assign gx_abs = gx[GDIF_W-1] ? GSUM_W'(-gx) : gx[GSUM_W-1:0];
    assign gy_abs = gy[GDIF_W-1] ? GSUM_W'(-gy) : gy[GSUM_W-1:0];

    assign mag_sum = {1'b0, gx_abs} + {1'b0, gy_abs};
    assign mag     = (mag_sum > MAG_W'(PIX_MAX)) ? PIX_MAX : mag_sum[PIX_W-1:0];

    // load when the output slot is empty or being taken
    assign pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mag_reg       <= mag;
            row_end_reg   <= head.row_end;
            frame_end_reg <= head.frame_end;
        end
    end

    assign out_valid      = out_valid_reg;
    assign edge_magnitude = mag_reg;
    assign row_end        = row_end_reg;
    assign frame_end      = frame_end_reg;

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!frame_end_reg || row_end_reg))
        else $error("frame end without row end");

endmodule

// ===== sv/rgb_gray_sobel_edge_top.sv =====
// top level of the rgb to gray sobel edge magnitude block
//
// usage
// - input channel: one bgr pixel word per accepted beat (blue, green, red),
//   in raster order, qualified by in_valid and held back by in_stall
// - output channel: one edge word per interior pixel (edge_magnitude,
//   row_end, frame_end), qualified by out_valid and held back by out_stall
// - config channel: cfg_index 0 sets frame_width, 1 sets frame_height;
//   cfg_ready is always high, write only while the stream is idle
// - sizes are clamped to 3..1024; output frame is (width-2) x (height-2)
// - path: an accepted pixel passes the luma stage register, the queue and the output register
// - throughput: one pixel per cycle while in_stall is low, set by the two line buffer rams that
//   are read on accept and written back the following cycle
// - receiver stall: results collect in a four word queue plus the output
//   register; in_stall rises once the queue has no room for the pixel
//   still in the luma stage
// - reset: counters, window and queue clear, sizes return to 640 x 480,
//   line buffer contents are left as they are and filled by rows 0 and 1
//
module rgb_gray_sobel_edge_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rgse_pkg::PIX_W-1:0]    blue,
    input  logic [rgse_pkg::PIX_W-1:0]    green,
    input  logic [rgse_pkg::PIX_W-1:0]    red,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rgse_pkg::PIX_W-1:0]    edge_magnitude,
    output logic                          row_end,
    output logic                          frame_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rgse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rgse_pkg::SIZE_W-1:0]   cfg_data
);
    import rgse_pkg::*;

    logic [SIZE_W-1:0] width_reg, height_reg;
    size_cfg_t         size_cfg;

    logic              push, pop, q_valid;
    win_t              push_win, head;
    logic [QCNT_W-1:0] q_count;

    // register file, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // sizes used by the counters, clamped to the supported range
    assign size_cfg.width  = clamp_size(width_reg, SIZE_W'(MAX_WIDTH));
    assign size_cfg.height = clamp_size(height_reg, SIZE_W'(ROW_LIMIT));

    // front: accept, count, luma, line buffers, window
    rgse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .size_cfg (size_cfg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .blue     (blue),
        .green    (green),
        .red      (red),
        .q_count  (q_count),
        .push     (push),
        .push_win (push_win)
    );

    // decoupling queue of interior windows
    rgse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_win (push_win),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head),
        .count    (q_count)
    );

    // back: gradient magnitude and output word
    rgse_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .edge_magnitude (edge_magnitude),
        .row_end        (row_end),
        .frame_end      (frame_end)
    );

endmodule
